@@ src/lfucr_pkg.sv @@
package lfucr_pkg;

  // cache geometry
  localparam int CACHE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(CACHE_SLOTS);
  localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);

  // field widths
  localparam int OP_W       = 2;
  localparam int NODE_W     = 24;
  localparam int TAG_W      = 16;
  localparam int HITS_W     = 32;
  localparam int OUT_SLOT_W = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [NODE_W-1:0]     NODE_LAST = '1;
  localparam logic [HITS_W-1:0]     HITS_MAX  = 32'hFFFF_FFFF;
  localparam logic [APB_ADDR_W-1:0] ADDR_INIT_COUNT = 3'd0;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ALLOC_CHK,
    ST_PICK,
    ST_SEARCH,
    ST_COMMIT,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic clr_scan;
    logic inc_scan;
    logic hit_upd;
    logic pick_fill;
    logic search_step;
    logic commit;
    logic emit_err;
    logic flush_step;
    logic emit_empty;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic scan_end;
    logic match;
    logic full;
    logic exhausted;
    logic search_stop;
    logic last_slot;
    logic vic_found;
    logic any_flushed;
  } stat_t;

endpackage

@@ src/lfucr_ctrl.sv @@
module lfucr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lfucr_pkg::stat_t stat,
  output lfucr_pkg::ctrl_t ctrl,
  output logic             busy
);
  import lfucr_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // the request is not registered yet, so decode it from the datapath view
          state_nxt = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (stat.scan_end) begin
          state_nxt = ST_PICK;
        end else if (stat.match) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ALLOC_CHK: begin
        state_nxt = stat.exhausted ? ST_IDLE : ST_PICK;
      end
      ST_PICK: begin
        state_nxt = stat.full ? ST_SEARCH : ST_COMMIT;
      end
      ST_SEARCH: begin
        if (stat.search_stop || stat.last_slot) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (stat.scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // dispatch on the incoming op
    if (accept) begin
      unique case (stat.op)
        OP_GET:   state_nxt = ST_LOOKUP;
        OP_ALLOC: state_nxt = ST_ALLOC_CHK;
        OP_FLUSH: state_nxt = ST_FLUSH;
        default:  state_nxt = ST_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.load_req = accept;
        ctrl.clr_scan = accept;
      end
      ST_LOOKUP: begin
        if (!stat.scan_end) begin
          if (stat.match) begin
            ctrl.hit_upd = 1'b1;
          end else begin
            ctrl.inc_scan = 1'b1;
          end
        end
      end
      ST_ALLOC_CHK: begin
        ctrl.emit_err = stat.exhausted;
      end
      ST_PICK: begin
        ctrl.clr_scan  = 1'b1;
        ctrl.pick_fill = !stat.full;
      end
      ST_SEARCH: begin
        ctrl.search_step = 1'b1;
        ctrl.inc_scan    = 1'b1;
      end
      ST_COMMIT: begin
        ctrl.commit   = stat.vic_found;
        ctrl.emit_err = !stat.vic_found;
      end
      ST_FLUSH: begin
        if (stat.scan_end) begin
          ctrl.emit_empty = !stat.any_flushed;
        end else begin
          ctrl.flush_step = 1'b1;
          ctrl.inc_scan   = 1'b1;
        end
      end
      default: ctrl = '0;
    endcase
  end

endmodule

@@ src/lfucr_dp.sv @@
module lfucr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  // request word
  input  logic [lfucr_pkg::OP_W-1:0]          in_op,
  input  logic [lfucr_pkg::NODE_W-1:0]        in_node_index,
  input  logic [lfucr_pkg::TAG_W-1:0]         in_operation_tag,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfucr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lfucr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lfucr_pkg::APB_DATA_W-1:0]    prdata,
  // control
  input  lfucr_pkg::ctrl_t                    ctrl,
  output lfucr_pkg::stat_t                    stat,
  // result word
  output logic                                out_valid,
  output logic [lfucr_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [lfucr_pkg::NODE_W-1:0]        out_result_node,
  output logic                                out_hit,
  output logic                                out_load_needed,
  output logic                                out_writeback_valid,
  output logic [lfucr_pkg::NODE_W-1:0]        out_writeback_node,
  output logic                                out_no_free_slot,
  output logic                                out_last
);
  import lfucr_pkg::*;

  // slot store
  logic [NODE_W-1:0]      slot_node_r [CACHE_SLOTS];
  logic [HITS_W-1:0]      slot_hits_r [CACHE_SLOTS];
  logic [TAG_W-1:0]       slot_tag_r  [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] slot_dirty_r;

  logic [CNT_W-1:0]  fill_count_r;
  logic [NODE_W-1:0] next_node_r;
  logic [NODE_W-1:0] init_count_r;

  // request and scan registers
  op_t               op_r;
  logic [NODE_W-1:0] node_r;
  logic [TAG_W-1:0]  tag_r;
  logic [CNT_W-1:0]  idx_r;
  logic [HITS_W-1:0] best_r;
  logic [SLOT_W-1:0] vic_r;
  logic              vic_found_r;
  logic              vic_dirty_r;
  logic [NODE_W-1:0] vic_node_r;
  logic              any_r;

  // result registers
  logic                  out_valid_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [NODE_W-1:0]     out_result_node_r;
  logic                  out_hit_r;
  logic                  out_load_needed_r;
  logic                  out_writeback_valid_r;
  logic [NODE_W-1:0]     out_writeback_node_r;
  logic                  out_no_free_slot_r;
  logic                  out_last_r;

  logic [SLOT_W-1:0] idx;
  logic [NODE_W-1:0] cur_node;
  logic [HITS_W-1:0] cur_hits;
  logic [TAG_W-1:0]  cur_tag;
  logic              cur_dirty;
  logic              candidate;
  logic              later_dirty;
  logic              cfg_wr;
  logic [NODE_W-1:0] new_node;

  assign idx       = idx_r[SLOT_W-1:0];
  assign cur_node  = slot_node_r[idx];
  assign cur_hits  = slot_hits_r[idx];
  assign cur_tag   = slot_tag_r[idx];
  assign cur_dirty = slot_dirty_r[idx];
  assign candidate = (cur_tag != tag_r) && (!vic_found_r || (cur_hits < best_r));
  assign new_node  = (op_r == OP_ALLOC) ? next_node_r : node_r;
  assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_INIT_COUNT);

  // dirty slots after the current one, for the flush end marker
  always_comb begin
    later_dirty = 1'b0;
    for (int j = 0; j < CACHE_SLOTS; j++) begin
      if (slot_dirty_r[j] && (CNT_W'(j) > idx_r) && (CNT_W'(j) < fill_count_r)) begin
        later_dirty = 1'b1;
      end
    end
  end

  // status to controller
  always_comb begin
    stat.op          = op_t'(in_op);
    stat.scan_end    = (idx_r == fill_count_r);
    stat.match       = (cur_node == node_r);
    stat.full        = (fill_count_r == CNT_W'(CACHE_SLOTS));
    stat.exhausted   = (next_node_r == NODE_LAST);
    stat.search_stop = candidate && (cur_hits == HITS_W'(1));
    stat.last_slot   = (idx_r == CNT_W'(CACHE_SLOTS - 1));
    stat.vic_found   = vic_found_r;
    stat.any_flushed = any_r;
  end

  // configuration register and readback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_count_r <= '0;
    end else if (cfg_wr) begin
      init_count_r <= pwdata[NODE_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_INIT_COUNT) ? APB_DATA_W'(init_count_r) : '0;

  // node counter and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_node_r  <= '0;
      fill_count_r <= '0;
    end else begin
      if (cfg_wr) begin
        next_node_r <= pwdata[NODE_W-1:0];
      end else if (ctrl.commit && (op_r == OP_ALLOC)) begin
        next_node_r <= next_node_r + NODE_W'(1);
      end
      if (ctrl.commit && (CNT_W'(vic_r) == fill_count_r) && (fill_count_r != CNT_W'(CACHE_SLOTS))) begin
        fill_count_r <= fill_count_r + CNT_W'(1);
      end
    end
  end

  // dirty bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_dirty_r <= '0;
    end else if (ctrl.commit) begin
      slot_dirty_r[vic_r] <= (op_r == OP_ALLOC);
    end else if (ctrl.flush_step) begin
      slot_dirty_r[idx] <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      slot_node_r[vic_r] <= new_node;
      slot_hits_r[vic_r] <= HITS_W'(1);
      slot_tag_r[vic_r]  <= tag_r;
    end else if (ctrl.hit_upd) begin
      if (cur_hits != HITS_MAX) begin
        slot_hits_r[idx] <= cur_hits + HITS_W'(1);
      end
      slot_tag_r[idx] <= tag_r;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      op_r   <= op_t'(in_op);
      node_r <= in_node_index;
      tag_r  <= in_operation_tag;
    end
  end

  // scan index and victim tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      vic_found_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      if (ctrl.clr_scan) begin
        idx_r <= '0;
        any_r <= 1'b0;
      end else if (ctrl.inc_scan) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      // a free slot or a new candidate wins over the scan clear
      if (ctrl.pick_fill || (ctrl.search_step && candidate)) begin
        vic_found_r <= 1'b1;
      end else if (ctrl.clr_scan) begin
        vic_found_r <= 1'b0;
      end
      if (ctrl.flush_step && cur_dirty) begin
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pick_fill) begin
      vic_r       <= fill_count_r[SLOT_W-1:0];
      vic_dirty_r <= 1'b0;
      vic_node_r  <= '0;
    end else if (ctrl.search_step && candidate) begin
      vic_r       <= idx;
      best_r      <= cur_hits;
      vic_dirty_r <= cur_dirty;
      vic_node_r  <= cur_node;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.hit_upd || ctrl.commit || ctrl.emit_err || ctrl.emit_empty ||
                     (ctrl.flush_step && cur_dirty);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctrl.hit_upd) begin
      out_slot_r            <= OUT_SLOT_W'(idx);
      out_result_node_r     <= node_r;
      out_hit_r             <= 1'b1;
      out_load_needed_r     <= 1'b0;
      out_writeback_valid_r <= 1'b0;
      out_writeback_node_r  <= '0;
      out_no_free_slot_r    <= 1'b0;
      out_last_r            <= 1'b1;
    end else if (ctrl.commit) begin
      out_slot_r            <= OUT_SLOT_W'(vic_r);
      out_result_node_r     <= new_node;
      out_hit_r             <= 1'b0;
      out_load_needed_r     <= (op_r == OP_GET);
      out_writeback_valid_r <= vic_dirty_r;
      out_writeback_node_r  <= vic_dirty_r ? vic_node_r : '0;
      out_no_free_slot_r    <= 1'b0;
      out_last_r            <= 1'b1;
    end else if (ctrl.flush_step && cur_dirty) begin
      out_slot_r            <= OUT_SLOT_W'(idx);
      out_result_node_r     <= cur_node;
      out_hit_r             <= 1'b0;
      out_load_needed_r     <= 1'b0;
      out_writeback_valid_r <= 1'b1;
      out_writeback_node_r  <= cur_node;
      out_no_free_slot_r    <= 1'b0;
      out_last_r            <= !later_dirty;
    end else if (ctrl.emit_err || ctrl.emit_empty) begin
      out_slot_r            <= '0;
      out_result_node_r     <= '0;
      out_hit_r             <= 1'b0;
      out_load_needed_r     <= 1'b0;
      out_writeback_valid_r <= 1'b0;
      out_writeback_node_r  <= '0;
      out_no_free_slot_r    <= ctrl.emit_err;
      out_last_r            <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot            = out_slot_r;
  assign out_result_node     = out_result_node_r;
  assign out_hit             = out_hit_r;
  assign out_load_needed     = out_load_needed_r;
  assign out_writeback_valid = out_writeback_valid_r;
  assign out_writeback_node  = out_writeback_node_r;
  assign out_no_free_slot    = out_no_free_slot_r;
  assign out_last            = out_last_r;

endmodule

@@ src/node_cache_lfu_replacement.sv @@
// Fully associative write-back node cache with least-frequently-used replacement.
// Request channel: in_op, in_node_index and in_operation_tag are taken at a clock
// edge with start high and busy low; busy stays high until the request is done.
// Result channel: each result word sits on the out_ ports for one cycle, marked by
// out_valid; the receiver cannot stall, so every word must be taken as it comes.
// Configuration: APB port, initial_node_count at byte address 0, pready tied high; the
// user must write only while busy is low (not checked); a write also reloads the node counter.
// Sequencing, set by the slot scan counter that walks one slot per cycle:
//   get hit on slot k: lookup walks slots 0 to k, then the result word is registered
//   get miss or allocate with a free slot: lookup (get only, over the filled slots),
//   then pick and commit; with the cache full, a victim search over up to 16 slots
//   lies between pick and commit (stops early on a hit count of one)
//   flush: walks the filled slots, one result word per dirty slot as it is found
// Reset (synchronous, rst_n low) empties the cache, clears every dirty bit and
// sets the node counter and initial_node_count to zero.
module node_cache_lfu_replacement (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [lfucr_pkg::OP_W-1:0]          in_op,
  input  logic [lfucr_pkg::NODE_W-1:0]        in_node_index,
  input  logic [lfucr_pkg::TAG_W-1:0]         in_operation_tag,
  // result channel
  output logic                                out_valid,
  output logic [lfucr_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [lfucr_pkg::NODE_W-1:0]        out_result_node,
  output logic                                out_hit,
  output logic                                out_load_needed,
  output logic                                out_writeback_valid,
  output logic [lfucr_pkg::NODE_W-1:0]        out_writeback_node,
  output logic                                out_no_free_slot,
  output logic                                out_last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfucr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lfucr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lfucr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import lfucr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign pready = 1'b1;

  // sequencer
  lfucr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // slot store, scan and result datapath
  lfucr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_node_index       (in_node_index),
    .in_operation_tag    (in_operation_tag),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .ctrl                (ctrl),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_slot            (out_slot),
    .out_result_node     (out_result_node),
    .out_hit             (out_hit),
    .out_load_needed     (out_load_needed),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_node  (out_writeback_node),
    .out_no_free_slot    (out_no_free_slot),
    .out_last            (out_last)
  );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import lfucr_pkg::*;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic [NODE_W-1:0]     node;
    logic                  hit;
    logic                  load_needed;
    logic                  wb_valid;
    logic [NODE_W-1:0]     wb_node;
    logic                  no_free;
    logic                  last;
  } word_t;

  localparam logic [TAG_W-1:0] PIN_TAG = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       in_op;
  logic [NODE_W-1:0]     in_node_index;
  logic [TAG_W-1:0]      in_operation_tag;
  logic                  out_valid;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [NODE_W-1:0]     out_result_node;
  logic                  out_hit;
  logic                  out_load_needed;
  logic                  out_writeback_valid;
  logic [NODE_W-1:0]     out_writeback_node;
  logic                  out_no_free_slot;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  node_cache_lfu_replacement dut (.*);

  // cache contents as the testbench tracks them
  int                cache_fill;
  logic [NODE_W-1:0] node_counter;
  logic [NODE_W-1:0] init_count;
  logic [NODE_W-1:0] cache_node  [CACHE_SLOTS];
  logic [HITS_W-1:0] cache_hits  [CACHE_SLOTS];
  logic [TAG_W-1:0]  cache_tag   [CACHE_SLOTS];
  logic              cache_dirty [CACHE_SLOTS];

  word_t            awaited_words[$];
  word_t            got_word;
  word_t            want_word;
  int               err_count;
  int               idle_pct;
  logic [TAG_W-1:0] op_tag;
  int               tag_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous upper bound on the whole run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic word_t make_word(input int slot, input logic [NODE_W-1:0] node,
                                      input logic hit, input logic load,
                                      input logic wbv, input logic [NODE_W-1:0] wbn,
                                      input logic no_free, input logic last);
    word_t w;
    w.slot        = OUT_SLOT_W'(slot);
    w.node        = node;
    w.hit         = hit;
    w.load_needed = load;
    w.wb_valid    = wbv;
    w.wb_node     = wbn;
    w.no_free     = no_free;
    w.last        = last;
    return w;
  endfunction

  function automatic string word_text(input word_t w);
    return $sformatf("slot=%0d node=%h hit=%b load=%b wb=%b/%h no_free=%b last=%b",
                     w.slot, w.node, w.hit, w.load_needed, w.wb_valid, w.wb_node,
                     w.no_free, w.last);
  endfunction

  // work out the result words of one accepted request and update the cache
  task automatic predict_access(input op_t op, input logic [NODE_W-1:0] node,
                                input logic [TAG_W-1:0] tag);
    int                victim;
    int                flushed;
    logic [HITS_W-1:0] best;
    word_t             w;
    best = '0;
    if (op == OP_NONE) return;

    // flush: one word per dirty slot, or a single empty word
    if (op == OP_FLUSH) begin
      flushed = 0;
      for (int i = 0; i < cache_fill; i++) begin
        if (cache_dirty[i]) begin
          awaited_words.push_back(make_word(i, cache_node[i], 0, 0, 1, cache_node[i], 0, 0));
          cache_dirty[i] = 1'b0;
          flushed++;
        end
      end
      if (flushed == 0) begin
        awaited_words.push_back(make_word(0, '0, 0, 0, 0, '0, 0, 1));
      end else begin
        w = awaited_words.pop_back();
        w.last = 1'b1;
        awaited_words.push_back(w);
      end
      return;
    end

    // lookup, lowest matching slot wins
    if (op == OP_GET) begin
      for (int i = 0; i < cache_fill; i++) begin
        if (cache_node[i] == node) begin
          if (cache_hits[i] != HITS_MAX) cache_hits[i]++;
          cache_tag[i] = tag;
          awaited_words.push_back(make_word(i, node, 1, 0, 0, '0, 0, 1));
          return;
        end
      end
    end

    // allocate takes the node counter unless it is used up
    if (op == OP_ALLOC) begin
      if (node_counter == NODE_LAST) begin
        awaited_words.push_back(make_word(0, '0, 0, 0, 0, '0, 1, 1));
        return;
      end
      node = node_counter;
    end

    // empty slot first, else first least-used slot not pinned by this tag
    victim = -1;
    if (cache_fill < CACHE_SLOTS) begin
      victim = cache_fill;
    end else begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (cache_tag[i] != tag && (victim < 0 || cache_hits[i] < best)) begin
          best   = cache_hits[i];
          victim = i;
          if (best == 1) break;
        end
      end
    end
    if (victim < 0) begin
      awaited_words.push_back(make_word(0, '0, 0, 0, 0, '0, 1, 1));
      return;
    end

    w = make_word(victim, node, 0, op == OP_GET, 0, '0, 0, 1);
    if (victim >= cache_fill) begin
      cache_fill++;
    end else if (cache_dirty[victim]) begin
      w.wb_valid = 1'b1;
      w.wb_node  = cache_node[victim];
    end
    cache_node[victim]  = node;
    cache_hits[victim]  = 1;
    cache_tag[victim]   = tag;
    cache_dirty[victim] = (op == OP_ALLOC);
    if (op == OP_ALLOC) node_counter = node_counter + 1'b1;
    awaited_words.push_back(w);
  endtask

  // result checker, the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word = {out_slot, out_result_node, out_hit, out_load_needed, out_writeback_valid,
                  out_writeback_node, out_no_free_slot, out_last};
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %s",
                 $time, word_text(got_word));
        err_count++;
      end else begin
        want_word = awaited_words.pop_front();
        if (got_word !== want_word) begin
          $display("%0t: result word mismatch, expected %s, actual %s",
                   $time, word_text(want_word), word_text(got_word));
          err_count++;
        end
      end
    end
  end

  // send one request, with an occasional gap ahead of it
  task automatic send_item(input op_t op, input logic [NODE_W-1:0] node,
                           input logic [TAG_W-1:0] tag);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_op            <= op;
    in_node_index    <= node;
    in_operation_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_access(op, node, tag);
  endtask

  // wait until every word has come and the block has gone quiet
  task automatic settle_block();
    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // write initial_node_count over apb and read it back
  task automatic write_init_count(input logic [NODE_W-1:0] value);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_INIT_COUNT;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    init_count   = value;
    node_counter = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_W'(init_count)) begin
      $display("%0t: initial_node_count read mismatch, expected %h, actual %h",
               $time, APB_DATA_W'(init_count), prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // flush of a clean cache and an ignored request code
  task automatic test_empty_flush();
    send_item(OP_FLUSH, '0, '0);
    send_item(OP_NONE, 24'h5A5A5A, 16'h1234);
  endtask

  // misses fill slots in order, hits bump counts, duplicate node takes lowest slot
  task automatic test_fill_and_hit();
    send_item(OP_GET, 24'd100, PIN_TAG);
    send_item(OP_ALLOC, 24'hA5A5A5, PIN_TAG);
    send_item(OP_GET, 24'd100, PIN_TAG);
    send_item(OP_GET, 24'd1, PIN_TAG);
    send_item(OP_ALLOC, '0, PIN_TAG);
    send_item(OP_GET, 24'd1, PIN_TAG);
    send_item(OP_GET, 24'hFFFFFF, PIN_TAG);
    for (int i = 0; i < 11; i++) send_item(OP_GET, NODE_W'(200 + i), PIN_TAG);
  endtask

  // every slot pinned by the current tag: no victim for get or allocate
  task automatic test_pinned_slots();
    send_item(OP_GET, 24'd300, PIN_TAG);
    send_item(OP_ALLOC, '0, PIN_TAG);
  endtask

  // new tag evicts a dirty slot, then flush the rest
  task automatic test_victim_writeback();
    send_item(OP_GET, 24'd300, '0);
    send_item(OP_FLUSH, '0, '0);
  endtask

  // node counter reaching its top value
  task automatic test_counter_exhaustion();
    write_init_count(24'hFFFFFE);
    send_item(OP_ALLOC, '0, 16'd1);
    send_item(OP_ALLOC, '0, 16'd1);
    write_init_count(24'hFFFFFF);
    send_item(OP_ALLOC, '0, 16'd2);
  endtask

  // tree-operation like traffic over several counter settings
  task automatic test_random_traffic();
    int               r;
    op_t              op;
    logic [NODE_W-1:0] node;
    logic [TAG_W-1:0] tag;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_init_count('0);
        1: write_init_count(NODE_W'($urandom_range(1, 24'hFFFF00)));
        2: write_init_count(24'hFFFFF0);
        default: write_init_count(NODE_W'($urandom));
      endcase
      // one phase runs with no gaps at all
      idle_pct = (phase == 1) ? 0 : 22;
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(99);
        if (r < 55)      op = OP_GET;
        else if (r < 78) op = OP_ALLOC;
        else if (r < 93) op = OP_FLUSH;
        else             op = OP_NONE;
        // mostly a small working set, some recently allocated, some anything
        r = $urandom_range(99);
        if (r < 50)      node = NODE_W'($urandom_range(0, 23));
        else if (r < 85) node = node_counter - NODE_W'($urandom_range(1, 8));
        else             node = NODE_W'($urandom);
        // tags come in runs, like the steps of one tree operation
        if (tag_left == 0) begin
          tag_left = $urandom_range(1, 30);
          op_tag   = ($urandom_range(99) < 80) ? TAG_W'($urandom_range(0, 3))
                                               : TAG_W'($urandom);
        end
        tag_left--;
        tag = ($urandom_range(99) < 10) ? TAG_W'($urandom) : op_tag;
        send_item(op, node, tag);
      end
    end
  endtask

  initial begin
    start            <= 1'b0;
    in_op            <= OP_GET;
    in_node_index    <= '0;
    in_operation_tag <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    err_count    = 0;
    idle_pct     = 22;
    op_tag       = '0;
    cache_fill   = 0;
    node_counter = '0;
    init_count   = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      cache_node[i]  = '0;
      cache_hits[i]  = '0;
      cache_tag[i]   = '0;
      cache_dirty[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_flush();
    test_fill_and_hit();
    test_pinned_slots();
    test_victim_writeback();
    test_counter_exhaustion();
    test_random_traffic();

    settle_block();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
